FILE: hw/rtl/ahbce_pkg.sv
// Shared types, constants and the byte-sequence step table of the half-block cell encoder.
// Depends on nothing; every other file of the encoder imports it.
package ahbce_pkg;

   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 1024;
   localparam int CMD_DEPTH    = 4;
   localparam int OUT_DEPTH    = 2;

   localparam int ROW_W  = 8;
   localparam int COL_W  = 10;
   localparam int CHAN_W = 8;
   localparam int RGB_W  = 3 * CHAN_W;
   localparam int NUM_W  = COL_W + 1;
   localparam int PC_W   = 6;

   typedef enum logic [1:0] {
      KIND_FRAME_BEGIN = 2'd0,
      KIND_CELL        = 2'd1,
      KIND_FRAME_END   = 2'd2,
      KIND_UNUSED      = 2'd3
   } item_kind_type;

   typedef enum logic [1:0] {
      CMD_SYNC_ON  = 2'd0,
      CMD_SYNC_OFF = 2'd1,
      CMD_CELL     = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic              need_pos;
      logic              same;
      logic              need_color;
      logic [ROW_W:0]    row1;
      logic [COL_W:0]    col1;
      logic [RGB_W-1:0]  top;
      logic [RGB_W-1:0]  bot;
   } cmd_type;

   typedef enum logic [2:0] {
      SRC_ROW   = 3'd0,
      SRC_COL   = 3'd1,
      SRC_TOP_R = 3'd2,
      SRC_TOP_G = 3'd3,
      SRC_TOP_B = 3'd4,
      SRC_BOT_R = 3'd5,
      SRC_BOT_G = 3'd6,
      SRC_BOT_B = 3'd7
   } num_src_type;

   typedef enum logic [2:0] {
      NXT_STEP      = 3'd0,
      NXT_AFTER_POS = 3'd1,
      NXT_SPACE     = 3'd2,
      NXT_BLOCK     = 3'd3,
      NXT_DONE      = 3'd4
   } step_next_type;

   typedef struct packed {
      logic          is_num;
      num_src_type   src;
      logic [7:0]    lit;
      step_next_type nxt;
   } step_type;

   localparam logic [PC_W-1:0] PC_SYNC_ON  = 6'd0;
   localparam logic [PC_W-1:0] PC_SYNC_OFF = 6'd8;
   localparam logic [PC_W-1:0] PC_POS      = 6'd16;
   localparam logic [PC_W-1:0] PC_BG       = 6'd22;
   localparam logic [PC_W-1:0] PC_FGBG     = 6'd35;
   localparam logic [PC_W-1:0] PC_SPACE    = 6'd59;
   localparam logic [PC_W-1:0] PC_BLOCK    = 6'd60;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_LOW_H = 8'h68;
   localparam logic [7:0] CH_LOW_L = 8'h6C;
   localparam logic [7:0] CH_LOW_M = 8'h6D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BLK0  = 8'hE2;
   localparam logic [7:0] CH_BLK1  = 8'h96;
   localparam logic [7:0] CH_BLK2  = 8'h80;

   function automatic step_type lit_step(logic [7:0] b, step_next_type nxt);
      step_type s;
      s.is_num = 1'b0;
      s.src    = SRC_ROW;
      s.lit    = b;
      s.nxt    = nxt;
      return s;
   endfunction

   function automatic step_type num_step(num_src_type src);
      step_type s;
      s.is_num = 1'b1;
      s.src    = src;
      s.lit    = CH_ZERO;
      s.nxt    = NXT_STEP;
      return s;
   endfunction

   function automatic step_type step_rom(logic [PC_W-1:0] pc);
      step_type s;
      unique case (pc)
         PC_SYNC_ON + 6'd0:   s = lit_step(CH_ESC, NXT_STEP);
         PC_SYNC_ON + 6'd1:   s = lit_step(CH_LBRK, NXT_STEP);
         PC_SYNC_ON + 6'd2:   s = lit_step(CH_QUEST, NXT_STEP);
         PC_SYNC_ON + 6'd3:   s = lit_step(CH_TWO, NXT_STEP);
         PC_SYNC_ON + 6'd4:   s = lit_step(CH_ZERO, NXT_STEP);
         PC_SYNC_ON + 6'd5:   s = lit_step(CH_TWO, NXT_STEP);
         PC_SYNC_ON + 6'd6:   s = lit_step(CH_SIX, NXT_STEP);
         PC_SYNC_ON + 6'd7:   s = lit_step(CH_LOW_H, NXT_DONE);
         PC_SYNC_OFF + 6'd0:  s = lit_step(CH_ESC, NXT_STEP);
         PC_SYNC_OFF + 6'd1:  s = lit_step(CH_LBRK, NXT_STEP);
         PC_SYNC_OFF + 6'd2:  s = lit_step(CH_QUEST, NXT_STEP);
         PC_SYNC_OFF + 6'd3:  s = lit_step(CH_TWO, NXT_STEP);
         PC_SYNC_OFF + 6'd4:  s = lit_step(CH_ZERO, NXT_STEP);
         PC_SYNC_OFF + 6'd5:  s = lit_step(CH_TWO, NXT_STEP);
         PC_SYNC_OFF + 6'd6:  s = lit_step(CH_SIX, NXT_STEP);
         PC_SYNC_OFF + 6'd7:  s = lit_step(CH_LOW_L, NXT_DONE);
         PC_POS + 6'd0:       s = lit_step(CH_ESC, NXT_STEP);
         PC_POS + 6'd1:       s = lit_step(CH_LBRK, NXT_STEP);
         PC_POS + 6'd2:       s = num_step(SRC_ROW);
         PC_POS + 6'd3:       s = lit_step(CH_SEMI, NXT_STEP);
         PC_POS + 6'd4:       s = num_step(SRC_COL);
         PC_POS + 6'd5:       s = lit_step(CH_H, NXT_AFTER_POS);
         PC_BG + 6'd0:        s = lit_step(CH_ESC, NXT_STEP);
         PC_BG + 6'd1:        s = lit_step(CH_LBRK, NXT_STEP);
         PC_BG + 6'd2:        s = lit_step(CH_FOUR, NXT_STEP);
         PC_BG + 6'd3:        s = lit_step(CH_EIGHT, NXT_STEP);
         PC_BG + 6'd4:        s = lit_step(CH_SEMI, NXT_STEP);
         PC_BG + 6'd5:        s = lit_step(CH_TWO, NXT_STEP);
         PC_BG + 6'd6:        s = lit_step(CH_SEMI, NXT_STEP);
         PC_BG + 6'd7:        s = num_step(SRC_BOT_R);
         PC_BG + 6'd8:        s = lit_step(CH_SEMI, NXT_STEP);
         PC_BG + 6'd9:        s = num_step(SRC_BOT_G);
         PC_BG + 6'd10:       s = lit_step(CH_SEMI, NXT_STEP);
         PC_BG + 6'd11:       s = num_step(SRC_BOT_B);
         PC_BG + 6'd12:       s = lit_step(CH_LOW_M, NXT_SPACE);
         PC_FGBG + 6'd0:      s = lit_step(CH_ESC, NXT_STEP);
         PC_FGBG + 6'd1:      s = lit_step(CH_LBRK, NXT_STEP);
         PC_FGBG + 6'd2:      s = lit_step(CH_THREE, NXT_STEP);
         PC_FGBG + 6'd3:      s = lit_step(CH_EIGHT, NXT_STEP);
         PC_FGBG + 6'd4:      s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd5:      s = lit_step(CH_TWO, NXT_STEP);
         PC_FGBG + 6'd6:      s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd7:      s = num_step(SRC_TOP_R);
         PC_FGBG + 6'd8:      s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd9:      s = num_step(SRC_TOP_G);
         PC_FGBG + 6'd10:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd11:     s = num_step(SRC_TOP_B);
         PC_FGBG + 6'd12:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd13:     s = lit_step(CH_FOUR, NXT_STEP);
         PC_FGBG + 6'd14:     s = lit_step(CH_EIGHT, NXT_STEP);
         PC_FGBG + 6'd15:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd16:     s = lit_step(CH_TWO, NXT_STEP);
         PC_FGBG + 6'd17:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd18:     s = num_step(SRC_BOT_R);
         PC_FGBG + 6'd19:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd20:     s = num_step(SRC_BOT_G);
         PC_FGBG + 6'd21:     s = lit_step(CH_SEMI, NXT_STEP);
         PC_FGBG + 6'd22:     s = num_step(SRC_BOT_B);
         PC_FGBG + 6'd23:     s = lit_step(CH_LOW_M, NXT_BLOCK);
         PC_SPACE:            s = lit_step(CH_SPACE, NXT_DONE);
         PC_BLOCK + 6'd0:     s = lit_step(CH_BLK0, NXT_STEP);
         PC_BLOCK + 6'd1:     s = lit_step(CH_BLK1, NXT_STEP);
         PC_BLOCK + 6'd2:     s = lit_step(CH_BLK2, NXT_DONE);
         default:             s = lit_step(CH_SPACE, NXT_DONE);
      endcase
      return s;
   endfunction

endpackage

FILE: hw/rtl/ansi_half_block_cell_encoder_unit.sv
// Top level of the ANSI truecolor half-block cell encoder: front end, command queue,
// back end and output queue. Depends on ahbce_pkg, ahbce_front, ahbce_fifo, ahbce_back.
//
// Usage: requests enter on a queue-style port (push/full); a request is taken at a clock
// edge with push high and full low. Frame begin emits the synchronized-update start
// sequence, frame end the end sequence, and a cell emits an optional cursor move, an
// optional color sequence and then a space or the upper half block. Requests of the
// unused kind or cells off the screen produce no bytes.
// Results leave one byte at a time on a queue-style port (empty/pop); rsp_last_byte marks
// the final byte of each request.
// A request is registered in the command queue and its first byte then in the output queue.
// Throughput: one byte per cycle while the output queue has room; a request emits 1 to 50
// bytes, and a frame marker emits 8. The back end digit unit emits each decimal digit as a
// byte of its own. The four-entry command queue lets the front end take new requests while
// the back end is still emitting.
// Reset clears the tracked cursor and colors and both queues.
// When the receiver holds pop low, the output queue fills, the back end stalls, then the
// command queue fills and full rises; nothing is dropped.
module ansi_half_block_cell_encoder_unit #(
   parameter int MAX_ROWS = ahbce_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = ahbce_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_type,
   input  logic [ahbce_pkg::ROW_W-1:0]   req_cell_row,
   input  logic [ahbce_pkg::COL_W-1:0]   req_cell_col,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_top_red,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_top_green,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_top_blue,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_bottom_red,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_bottom_green,
   input  logic [ahbce_pkg::CHAN_W-1:0]  req_bottom_blue,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_byte
);
   import ahbce_pkg::*;

   localparam int OutW = 9;

   logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type          cmd_wr, cmd_rd;
   logic             out_push, out_full, out_last;
   logic [7:0]       out_byte;
   logic [OutW-1:0]  out_rd;

   ahbce_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_type     (req_type),
      .req_cell_row (req_cell_row),
      .req_cell_col (req_cell_col),
      .top_rgb      ({req_top_red, req_top_green, req_top_blue}),
      .bot_rgb      ({req_bottom_red, req_bottom_green, req_bottom_blue}),
      .cmd_push     (cmd_push),
      .cmd          (cmd_wr),
      .cmd_full     (cmd_full)
   );

   ahbce_fifo #(
      .Width ($bits(cmd_type)),
      .Depth (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   ahbce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_byte  (out_byte),
      .out_last  (out_last)
   );

   ahbce_fifo #(
      .Width (OutW),
      .Depth (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data ({out_byte, out_last}),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_rd),
      .empty   (empty)
   );

   assign rsp_out_byte  = out_rd[OutW-1:1];
   assign rsp_last_byte = out_rd[0];

endmodule

FILE: hw/rtl/ahbce_fifo.sv
// Small register-file queue with full and empty flags, used for commands and output bytes.
// Depends on ahbce_pkg for default sizes.
module ahbce_fifo #(
   parameter int Width = 9,
   parameter int Depth = ahbce_pkg::OUT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [Width-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [Width-1:0] rd_data,
   output logic             empty
);
   import ahbce_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/ahbce_front.sv
// Front end: accepts requests, tracks cursor and colors, and issues at most one command per request.
// Depends on ahbce_pkg for the command type and item kinds.
module ahbce_front #(
   parameter int MAX_ROWS = ahbce_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = ahbce_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_type,
   input  logic [ahbce_pkg::ROW_W-1:0]   req_cell_row,
   input  logic [ahbce_pkg::COL_W-1:0]   req_cell_col,
   input  logic [ahbce_pkg::RGB_W-1:0]   top_rgb,
   input  logic [ahbce_pkg::RGB_W-1:0]   bot_rgb,
   output logic                          cmd_push,
   output ahbce_pkg::cmd_type            cmd,
   input  logic                          cmd_full
);
   import ahbce_pkg::*;

   localparam logic [ROW_W:0] RowLimit = (ROW_W + 1)'(MAX_ROWS);
   localparam logic [COL_W:0] ColLimit = (COL_W + 1)'(MAX_COLS);

   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W:0]   cur_col_ff, cur_col_in;
   logic             cur_known_ff, cur_known_in;
   logic [RGB_W-1:0] fore_ff, fore_in;
   logic             fore_known_ff, fore_known_in;
   logic [RGB_W-1:0] back_ff, back_in;
   logic             back_known_ff, back_known_in;

   logic             accept;
   logic             in_range;
   logic             same;
   logic             back_diff;
   logic             need_color;
   item_kind_type    kind;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;
   assign kind   = item_kind_type'(req_type);

   assign in_range   = ({1'b0, req_cell_row} < RowLimit) && ({1'b0, req_cell_col} < ColLimit);
   assign same       = (top_rgb == bot_rgb);
   assign back_diff  = !back_known_ff || (back_ff != bot_rgb);
   assign need_color = same ? back_diff
                            : (back_diff || !fore_known_ff || (fore_ff != top_rgb));

   always_comb begin
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_known_in  = cur_known_ff;
      fore_in       = fore_ff;
      fore_known_in = fore_known_ff;
      back_in       = back_ff;
      back_known_in = back_known_ff;
      cmd_push      = 1'b0;

      cmd.kind       = CMD_CELL;
      cmd.need_pos   = !cur_known_ff || (req_cell_row != cur_row_ff) ||
                       ({1'b0, req_cell_col} != cur_col_ff);
      cmd.same       = same;
      cmd.need_color = need_color;
      cmd.row1       = {1'b0, req_cell_row} + 1'b1;
      cmd.col1       = {1'b0, req_cell_col} + 1'b1;
      cmd.top        = top_rgb;
      cmd.bot        = bot_rgb;

      if (accept) begin
         unique case (kind)
            KIND_FRAME_BEGIN: begin
               cmd.kind      = CMD_SYNC_ON;
               cmd_push      = 1'b1;
               cur_known_in  = 1'b0;
               fore_known_in = 1'b0;
               back_known_in = 1'b0;
            end
            KIND_FRAME_END: begin
               cmd.kind = CMD_SYNC_OFF;
               cmd_push = 1'b1;
            end
            KIND_CELL: begin
               if (in_range) begin
                  cmd_push     = 1'b1;
                  cur_row_in   = req_cell_row;
                  cur_col_in   = cmd.col1;
                  cur_known_in = 1'b1;
                  if (need_color) begin
                     back_in       = bot_rgb;
                     back_known_in = 1'b1;
                     if (!same) begin
                        fore_in       = top_rgb;
                        fore_known_in = 1'b1;
                     end
                  end
               end
            end
            KIND_UNUSED: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_known_ff  <= 1'b0;
         fore_known_ff <= 1'b0;
         back_known_ff <= 1'b0;
      end else begin
         cur_known_ff  <= cur_known_in;
         fore_known_ff <= fore_known_in;
         back_known_ff <= back_known_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff <= cur_row_in;
      cur_col_ff <= cur_col_in;
      fore_ff    <= fore_in;
      back_ff    <= back_in;
   end

endmodule

FILE: hw/rtl/ahbce_back.sv
// Back end: walks the step table for the head command and emits one byte per cycle while
// out_full is low, expanding decimal numbers one digit per cycle. Depends on ahbce_pkg.
module ahbce_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  ahbce_pkg::cmd_type cmd,
   output logic               cmd_pop,
   input  logic               out_full,
   output logic               out_push,
   output logic [7:0]         out_byte,
   output logic               out_last
);
   import ahbce_pkg::*;

   localparam int WideW = NUM_W + 3;

   logic              active_ff, active_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              in_num_ff, in_num_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [1:0]        place_ff, place_in;

   logic              go;
   logic [PC_W-1:0]   color_pc, start_pc, pc_cur;
   step_type          step;
   logic [NUM_W-1:0]  src_val, r_cur;
   logic [1:0]        src_mag, p_cur;
   logic [WideW-1:0]  pw, sub;
   logic [3:0]        digit;
   logic              step_done;

   function automatic logic [1:0] magnitude(logic [NUM_W-1:0] v);
      logic [1:0] m;
      if (v >= NUM_W'(1000)) begin
         m = 2'd3;
      end else if (v >= NUM_W'(100)) begin
         m = 2'd2;
      end else if (v >= NUM_W'(10)) begin
         m = 2'd1;
      end else begin
         m = 2'd0;
      end
      return m;
   endfunction

   assign go = cmd_valid && !out_full;

   always_comb begin
      if (cmd.same) begin
         color_pc = cmd.need_color ? PC_BG : PC_SPACE;
      end else begin
         color_pc = cmd.need_color ? PC_FGBG : PC_BLOCK;
      end
      unique case (cmd.kind)
         CMD_SYNC_ON:  start_pc = PC_SYNC_ON;
         CMD_SYNC_OFF: start_pc = PC_SYNC_OFF;
         default:      start_pc = cmd.need_pos ? PC_POS : color_pc;
      endcase
   end

   assign pc_cur = active_ff ? pc_ff : start_pc;
   assign step   = step_rom(pc_cur);

   always_comb begin
      unique case (step.src)
         SRC_ROW:   src_val = NUM_W'(cmd.row1);
         SRC_COL:   src_val = cmd.col1;
         SRC_TOP_R: src_val = NUM_W'(cmd.top[23:16]);
         SRC_TOP_G: src_val = NUM_W'(cmd.top[15:8]);
         SRC_TOP_B: src_val = NUM_W'(cmd.top[7:0]);
         SRC_BOT_R: src_val = NUM_W'(cmd.bot[23:16]);
         SRC_BOT_G: src_val = NUM_W'(cmd.bot[15:8]);
         SRC_BOT_B: src_val = NUM_W'(cmd.bot[7:0]);
      endcase
   end

   assign src_mag = magnitude(src_val);
   assign r_cur   = in_num_ff ? rem_ff : src_val;
   assign p_cur   = in_num_ff ? place_ff : src_mag;

   always_comb begin
      unique case (p_cur)
         2'd0: pw = WideW'(1);
         2'd1: pw = WideW'(10);
         2'd2: pw = WideW'(100);
         2'd3: pw = WideW'(1000);
      endcase
      digit = 4'd0;
      sub   = '0;
      for (int j = 1; j < 10; j++) begin
         if ({3'b000, r_cur} >= WideW'(j) * pw) begin
            digit = 4'(j);
            sub   = WideW'(j) * pw;
         end
      end
   end

   assign step_done = !step.is_num || (p_cur == 2'd0);
   assign out_byte  = step.is_num ? (CH_ZERO + {4'b0000, digit}) : step.lit;
   assign out_last  = step_done && (step.nxt == NXT_DONE);
   assign out_push  = go;
   assign cmd_pop   = go && out_last;

   always_comb begin
      active_in = active_ff;
      pc_in     = pc_ff;
      in_num_in = in_num_ff;
      rem_in    = rem_ff;
      place_in  = place_ff;
      if (go) begin
         if (!step_done) begin
            in_num_in = 1'b1;
            rem_in    = r_cur - sub[NUM_W-1:0];
            place_in  = p_cur - 1'b1;
            pc_in     = pc_cur;
            active_in = 1'b1;
         end else begin
            in_num_in = 1'b0;
            active_in = 1'b1;
            unique case (step.nxt)
               NXT_STEP:      pc_in = pc_cur + 1'b1;
               NXT_AFTER_POS: pc_in = color_pc;
               NXT_SPACE:     pc_in = PC_SPACE;
               NXT_BLOCK:     pc_in = PC_BLOCK;
               default:       active_in = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         in_num_ff <= 1'b0;
         pc_ff     <= '0;
      end else begin
         active_ff <= active_in;
         in_num_ff <= in_num_in;
         pc_ff     <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      place_ff <= place_in;
   end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the ANSI truecolor half-block cell encoder.
// Predicts the escape byte stream of every request and checks it byte by byte.
// Depends on ahbce_pkg and ansi_half_block_cell_encoder_unit.
`timescale 1ns / 100ps

module tb_top;
   import ahbce_pkg::*;

   localparam int SCREEN_ROWS = DEF_MAX_ROWS;
   localparam int SCREEN_COLS = DEF_MAX_COLS;
   localparam int RANDOM_REQS = 480;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_START = 1500;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      item_kind_type      kind;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [RGB_W-1:0]   top;
      logic [RGB_W-1:0]   bot;
   } term_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [1:0]          req_type = KIND_FRAME_BEGIN;
   logic [ROW_W-1:0]    req_cell_row = '0;
   logic [COL_W-1:0]    req_cell_col = '0;
   logic [CHAN_W-1:0]   req_top_red = '0;
   logic [CHAN_W-1:0]   req_top_green = '0;
   logic [CHAN_W-1:0]   req_top_blue = '0;
   logic [CHAN_W-1:0]   req_bottom_red = '0;
   logic [CHAN_W-1:0]   req_bottom_green = '0;
   logic [CHAN_W-1:0]   req_bottom_blue = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [7:0]          rsp_out_byte;
   logic                rsp_last_byte;

   term_req_type        req_q[$];
   logic [7:0]          esc_byte_q[$];
   bit                  esc_last_q[$];

   logic [ROW_W-1:0]    trk_row = '0;
   logic [NUM_W-1:0]    trk_col = '0;
   bit                  trk_pos_ok = 1'b0;
   logic [RGB_W-1:0]    trk_fg = '0;
   bit                  trk_fg_ok = 1'b0;
   logic [RGB_W-1:0]    trk_bg = '0;
   bit                  trk_bg_ok = 1'b0;

   bit                  took = 1'b0;
   int                  burst_left = 1;
   int                  gap_left = 0;
   int                  rx_cycle = 0;
   int                  hold_left = 0;
   int                  idle_cycles = 0;
   int                  err_count = 0;
   logic [7:0]          want_byte;
   bit                  want_last;

   ansi_half_block_cell_encoder_unit #(
      .MAX_ROWS(SCREEN_ROWS),
      .MAX_COLS(SCREEN_COLS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_cell_row(req_cell_row),
      .req_cell_col(req_cell_col),
      .req_top_red(req_top_red),
      .req_top_green(req_top_green),
      .req_top_blue(req_top_blue),
      .req_bottom_red(req_bottom_red),
      .req_bottom_green(req_bottom_green),
      .req_bottom_blue(req_bottom_blue),
      .empty(empty),
      .pop(pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   always #10 clock = ~clock;

   task automatic put_esc(input logic [7:0] b);
      esc_byte_q.push_back(b);
      esc_last_q.push_back(1'b0);
   endtask

   task automatic put_dec(input int v);
      if (v >= 1000) put_esc(8'(int'(CH_ZERO) + v / 1000));
      if (v >= 100) put_esc(8'(int'(CH_ZERO) + (v / 100) % 10));
      if (v >= 10) put_esc(8'(int'(CH_ZERO) + (v / 10) % 10));
      put_esc(8'(int'(CH_ZERO) + v % 10));
   endtask

   task automatic put_sync(input logic [7:0] tail);
      put_esc(CH_ESC);
      put_esc(CH_LBRK);
      put_esc(CH_QUEST);
      put_esc(CH_TWO);
      put_esc(CH_ZERO);
      put_esc(CH_TWO);
      put_esc(CH_SIX);
      put_esc(tail);
   endtask

   // <lead>8;2;R;G;B (the caller emits ESC [ before it)
   task automatic put_color(input logic [7:0] lead, input logic [RGB_W-1:0] rgb);
      put_esc(lead);
      put_esc(CH_EIGHT);
      put_esc(CH_SEMI);
      put_esc(CH_TWO);
      put_esc(CH_SEMI);
      put_dec(int'(rgb[23:16]));
      put_esc(CH_SEMI);
      put_dec(int'(rgb[15:8]));
      put_esc(CH_SEMI);
      put_dec(int'(rgb[7:0]));
   endtask

   task automatic predict_escape_bytes(input item_kind_type kind, input logic [ROW_W-1:0] row,
                                       input logic [COL_W-1:0] col,
                                       input logic [RGB_W-1:0] top,
                                       input logic [RGB_W-1:0] bot);
      int start;
      start = esc_byte_q.size();
      case (kind)
         KIND_FRAME_BEGIN: begin
            put_sync(CH_LOW_H);
            trk_pos_ok = 1'b0;
            trk_fg_ok = 1'b0;
            trk_bg_ok = 1'b0;
         end
         KIND_FRAME_END: begin
            put_sync(CH_LOW_L);
         end
         KIND_CELL: begin
            if (int'(row) < SCREEN_ROWS && int'(col) < SCREEN_COLS) begin
               if (!trk_pos_ok || row != trk_row || {1'b0, col} != trk_col) begin
                  put_esc(CH_ESC);
                  put_esc(CH_LBRK);
                  put_dec(int'(row) + 1);
                  put_esc(CH_SEMI);
                  put_dec(int'(col) + 1);
                  put_esc(CH_H);
                  trk_row = row;
                  trk_col = {1'b0, col};
                  trk_pos_ok = 1'b1;
               end
               if (top == bot) begin
                  if (!trk_bg_ok || trk_bg != bot) begin
                     put_esc(CH_ESC);
                     put_esc(CH_LBRK);
                     put_color(CH_FOUR, bot);
                     put_esc(CH_LOW_M);
                     trk_bg = bot;
                     trk_bg_ok = 1'b1;
                  end
                  put_esc(CH_SPACE);
               end else begin
                  if (!trk_fg_ok || trk_fg != top || !trk_bg_ok || trk_bg != bot) begin
                     put_esc(CH_ESC);
                     put_esc(CH_LBRK);
                     put_color(CH_THREE, top);
                     put_esc(CH_SEMI);
                     put_color(CH_FOUR, bot);
                     put_esc(CH_LOW_M);
                     trk_fg = top;
                     trk_fg_ok = 1'b1;
                     trk_bg = bot;
                     trk_bg_ok = 1'b1;
                  end
                  put_esc(CH_BLK0);
                  put_esc(CH_BLK1);
                  put_esc(CH_BLK2);
               end
               trk_col = trk_col + 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (esc_byte_q.size() > start) esc_last_q[esc_last_q.size() - 1] = 1'b1;
   endtask

   task automatic queue_req(input item_kind_type kind, input int row, input int col,
                            input logic [RGB_W-1:0] top, input logic [RGB_W-1:0] bot);
      term_req_type r;
      r.kind = kind;
      r.row = ROW_W'(row);
      r.col = COL_W'(col);
      r.top = top;
      r.bot = bot;
      req_q.push_back(r);
   endtask

   // sender: hold each request until taken, then advance; bursts separated by optional gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (took) begin
            void'(req_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (gap_left > 0 || req_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            push <= 1'b0;
         end else begin
            push <= 1'b1;
            req_type <= req_q[0].kind;
            req_cell_row <= req_q[0].row;
            req_cell_col <= req_q[0].col;
            {req_top_red, req_top_green, req_top_blue} <= req_q[0].top;
            {req_bottom_red, req_bottom_green, req_bottom_blue} <= req_q[0].bot;
         end
      end
   end

   // receiver: one long hold-off, otherwise a rotating stall pattern
   always @(negedge clock) begin
      rx_cycle++;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case ((rx_cycle / 128) % 4)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= ((rx_cycle % 8) < 5);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      took = !reset && push && !full;
      if (took) begin
         predict_escape_bytes(item_kind_type'(req_type), req_cell_row, req_cell_col,
                              {req_top_red, req_top_green, req_top_blue},
                              {req_bottom_red, req_bottom_green, req_bottom_blue});
      end
      if (!reset && pop && !empty) begin
         if (esc_byte_q.size() == 0) begin
            $display("%0t: unexpected byte, expected none, got %h last %b",
                     $time, rsp_out_byte, rsp_last_byte);
            err_count++;
         end else begin
            want_byte = esc_byte_q.pop_front();
            want_last = esc_last_q.pop_front();
            if (rsp_out_byte !== want_byte) begin
               $display("%0t: out_byte mismatch, expected %h, got %h",
                        $time, want_byte, rsp_out_byte);
               err_count++;
            end
            if (rsp_last_byte !== want_last) begin
               $display("%0t: last_byte mismatch, expected %b, got %b",
                        $time, want_last, rsp_last_byte);
               err_count++;
            end
         end
      end
      if (took || (!reset && pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [RGB_W-1:0] pal[4];
      logic [RGB_W-1:0] top;
      logic [RGB_W-1:0] bot;
      int row;
      int col;
      int ncells;
      int sel;
      int counted;

      queue_req(KIND_CELL, 0, 0, 24'h000000, 24'h000000);
      queue_req(KIND_FRAME_BEGIN, 0, 0, 24'h000000, 24'h000000);
      queue_req(KIND_CELL, 0, 0, 24'h000000, 24'h000000);
      queue_req(KIND_CELL, 0, 1, 24'h000000, 24'h000000);
      queue_req(KIND_CELL, 0, 2, 24'hffffff, 24'h000000);
      queue_req(KIND_CELL, 0, 3, 24'hffffff, 24'h000000);
      queue_req(KIND_CELL, 255, 1023, 24'hffffff, 24'hffffff);
      queue_req(KIND_CELL, 255, 1023, 24'hffffff, 24'hffffff);
      queue_req(KIND_CELL, 255, 0, 24'hffffff, 24'hffffff);
      queue_req(KIND_UNUSED, 255, 1023, 24'hffffff, 24'hffffff);
      queue_req(KIND_FRAME_END, 0, 0, 24'h000000, 24'h000000);
      queue_req(KIND_CELL, 255, 1, 24'hffffff, 24'hffffff);
      queue_req(KIND_CELL, 255, 2, 24'hffffff, 24'h000001);
      queue_req(KIND_CELL, 255, 3, 24'h000001, 24'h000001);
      queue_req(KIND_CELL, 255, 4, 24'h000002, 24'h000001);
      queue_req(KIND_FRAME_BEGIN, 0, 0, 24'h000000, 24'h000000);
      queue_req(KIND_CELL, 255, 5, 24'h000002, 24'h000001);
      queue_req(KIND_CELL, 9, 98, 24'h090a63, 24'h64c8ff);
      queue_req(KIND_CELL, 98, 99, 24'h64c8ff, 24'h090a63);
      queue_req(KIND_CELL, 99, 999, 24'h0a6309, 24'h0a6309);
      queue_req(KIND_UNUSED, 170, 682, 24'h55aa55, 24'haa55aa);
      queue_req(KIND_FRAME_END, 0, 0, 24'h000000, 24'h000000);

      counted = 0;
      while (counted < RANDOM_REQS) begin
         for (int i = 0; i < 4; i++) begin
            sel = $urandom_range(0, 7);
            pal[i] = (sel == 0) ? 24'h000000 : (sel == 1) ? 24'hffffff : 24'($urandom);
         end
         if ($urandom_range(0, 9) != 0) begin
            queue_req(KIND_FRAME_BEGIN, $urandom, $urandom, 24'($urandom), 24'($urandom));
            counted++;
         end
         row = $urandom_range(0, SCREEN_ROWS - 1);
         col = $urandom_range(0, SCREEN_COLS - 1);
         ncells = $urandom_range(4, 30);
         for (int i = 0; i < ncells; i++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
               queue_req(KIND_UNUSED, $urandom, $urandom, 24'($urandom), 24'($urandom));
            end else begin
               if (sel == 1) begin
                  row = $urandom_range(0, SCREEN_ROWS - 1);
                  col = $urandom_range(0, SCREEN_COLS - 1);
               end else if (sel == 2) begin
                  col = $urandom_range(SCREEN_COLS - 3, SCREEN_COLS - 1);
               end
               if (col >= SCREEN_COLS) begin
                  col = 0;
                  row = (row + 1) % SCREEN_ROWS;
               end
               top = (sel == 3) ? 24'($urandom) : pal[$urandom_range(0, 3)];
               bot = ($urandom_range(0, 2) == 0) ? top : pal[$urandom_range(0, 3)];
               queue_req(KIND_CELL, row, col, top, bot);
               counted++;
               // an occasional stray column keeps the cursor tracking honest
               if ($urandom_range(0, 15) != 0) col++;
            end
         end
         if ($urandom_range(0, 9) != 0) begin
            queue_req(KIND_FRAME_END, $urandom, $urandom, 24'($urandom), 24'($urandom));
            counted++;
         end
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      while (req_q.size() != 0 || push || esc_byte_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && esc_byte_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
